// ===== rtl/greedy_change_dispenser_macros.svh =====
// Assertion macros used by the greedy change dispenser top module.
`ifndef GREEDY_CHANGE_DISPENSER_MACROS_SVH
`define GREEDY_CHANGE_DISPENSER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define GCD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define GCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gcd_pkg.sv =====
// Package with the widths, codes and defaults of the greedy change dispenser.
`timescale 1ns / 1ps

package gcd_pkg;

  // Default parameter values.
  localparam int unsigned MAX_DENOMS_DEF  = 16;
  localparam int unsigned AMOUNT_BITS_DEF = 20;

  // Fixed field widths.
  localparam int unsigned DENOM_W   = 20;
  localparam int unsigned AVAIL_W   = 16;
  localparam int unsigned COUNT_W   = 20;
  localparam int unsigned IDX_IN_W  = 4;
  localparam int unsigned IDX_OUT_W = 4;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned DIU_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 5;

  // Request opcodes.
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_COUNT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOCHANGE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE     = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DENOMS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_LIMITS    = 1'b1;

endpackage

// ===== rtl/greedy_change_dispenser.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  opcode, entry_index, denom_write,
//                                             avail_write, price, paid
// out       output     out_valid_o/out_stall_i kind, denom_index, denom_value,
//                                             piece_count, leftover, last
// cfg       input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// A table write leaves the block idle, so it is ready again at once.
// A request with no change due goes straight to the output handshake.
// Each table entry in use costs a read, a load, a bit-serial divide of
// min(AMOUNT_BITS, 20) bits and a check, plus a pass through the serial
// multiplier when a count is capped and an emit for each result sent.
// Reset clears control and configuration; the tables are undefined until
// written and get no clearing pass. A stalled result holds the block.
`timescale 1ns / 1ps

`include "greedy_change_dispenser_macros.svh"

module greedy_change_dispenser import gcd_pkg::*; #(
  parameter int unsigned MAX_DENOMS  = MAX_DENOMS_DEF,
  parameter int unsigned AMOUNT_BITS = AMOUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration writes.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  // Request channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 opcode_i,
  input  logic [IDX_IN_W-1:0]  entry_index_i,
  input  logic [DENOM_W-1:0]   denom_write_i,
  input  logic [AVAIL_W-1:0]   avail_write_i,
  input  logic [DENOM_W-1:0]   price_i,
  input  logic [DENOM_W-1:0]   paid_i,
  // Result channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [KIND_W-1:0]    kind_o,
  output logic [IDX_OUT_W-1:0] denom_index_o,
  output logic [DENOM_W-1:0]   denom_value_o,
  output logic [COUNT_W-1:0]   piece_count_o,
  output logic [COUNT_W-1:0]   leftover_o,
  output logic                 last_o
);

  localparam int unsigned RemW = (AMOUNT_BITS < DENOM_W) ? AMOUNT_BITS : DENOM_W;
  localparam int unsigned IdxW = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
  localparam int unsigned CntW = $clog2(MAX_DENOMS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_DIV,
    S_CAP,
    S_MUL,
    S_EMIT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [DIU_W-1:0] diu_q;
  logic             use_limits_q;

  // Sequencer registers.
  logic [CntW-1:0] j_q;
  logic [CntW-1:0] n_q;
  logic [RemW-1:0] rem_q;

  // Output register.
  logic                 out_valid_q;
  logic [KIND_W-1:0]    kind_q;
  logic [IDX_OUT_W-1:0] idx_q;
  logic [DENOM_W-1:0]   value_q;
  logic [COUNT_W-1:0]   count_q;
  logic [COUNT_W-1:0]   left_q;
  logic                 last_q;

  // Table memory and its registered read data.
  logic [DENOM_W-1:0] denom_mem [MAX_DENOMS];
  logic [AVAIL_W-1:0] avail_mem [MAX_DENOMS];
  logic [DENOM_W-1:0] rd_denom_q;
  logic [AVAIL_W-1:0] rd_avail_q;

  logic            in_acc;
  logic            mem_we;
  logic            mem_re;
  logic [RemW-1:0] price_m, paid_m;
  logic [CntW-1:0] n_eff;
  logic            div_start, div_done;
  logic [RemW-1:0] quot, remd;
  logic            mul_start, mul_done;
  logic [RemW-1:0] prod;
  logic            cap;
  logic            fin_en;
  logic [RemW-1:0] fin_cnt, fin_rem;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign mem_we     = in_acc && (opcode_i == OP_WRITE) &&
                      (32'(entry_index_i) < MAX_DENOMS);
  assign mem_re     = (state_q == S_READ) && (j_q < n_q);

  // Amounts are kept in RemW bits; the table size limits the entries in use.
  assign price_m = price_i[RemW-1:0];
  assign paid_m  = paid_i[RemW-1:0];
  assign n_eff   = (32'(diu_q) > MAX_DENOMS) ? CntW'(MAX_DENOMS) : CntW'(diu_q);

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diu_q        <= '0;
      use_limits_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DENOMS_IN_USE: diu_q        <= cfg_wdata_i[DIU_W-1:0];
        CFG_USE_LIMITS:    use_limits_q <= cfg_wdata_i[0];
        default:           ;
      endcase
    end
  end

  // Table memory: written by table items, read one entry per denomination.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      denom_mem[IdxW'(entry_index_i)] <= denom_write_i;
      avail_mem[IdxW'(entry_index_i)] <= avail_write_i;
    end
    if (mem_re) begin
      rd_denom_q <= denom_mem[j_q[IdxW-1:0]];
      rd_avail_q <= avail_mem[j_q[IdxW-1:0]];
    end
  end

  // Serial arithmetic units.
  assign div_start = (state_q == S_LOAD) && (rd_denom_q != '0);
  assign cap       = use_limits_q && (32'(quot) > 32'(rd_avail_q));
  assign mul_start = (state_q == S_CAP) && cap;

  gcd_divider #(
    .RemW (RemW)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (rem_q),
    .divisor_i   (rd_denom_q),
    .done_o      (div_done),
    .quotient_o  (quot),
    .remainder_o (remd)
  );

  gcd_multiplier #(
    .RemW (RemW)
  ) u_multiplier (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (mul_start),
    .multiplier_i   (rd_avail_q),
    .multiplicand_i (rd_denom_q[RemW-1:0]),
    .done_o         (mul_done),
    .product_o      (prod)
  );

  // Count and new remainder of the current denomination.
  always_comb begin
    fin_en  = ((state_q == S_CAP) && !cap) || ((state_q == S_MUL) && mul_done);
    fin_cnt = quot;
    fin_rem = remd;
    if (state_q == S_MUL) begin
      fin_cnt = RemW'(rd_avail_q);
      fin_rem = rem_q - prod;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      j_q         <= '0;
      n_q         <= '0;
      rem_q       <= '0;
      kind_q      <= KIND_COUNT;
      idx_q       <= '0;
      value_q     <= '0;
      count_q     <= '0;
      left_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && (opcode_i == OP_REQUEST)) begin
            if (paid_m <= price_m) begin
              out_valid_q <= 1'b1;
              kind_q      <= KIND_NOCHANGE;
              idx_q       <= '0;
              value_q     <= '0;
              count_q     <= '0;
              left_q      <= '0;
              last_q      <= 1'b1;
              state_q     <= S_EMIT;
            end else begin
              rem_q   <= paid_m - price_m;
              n_q     <= n_eff;
              j_q     <= '0;
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          if (j_q < n_q) begin
            state_q <= S_LOAD;
          end else begin
            out_valid_q <= 1'b1;
            kind_q      <= KIND_DONE;
            idx_q       <= '0;
            value_q     <= '0;
            count_q     <= '0;
            left_q      <= COUNT_W'(rem_q);
            last_q      <= 1'b1;
            state_q     <= S_EMIT;
          end
        end
        S_LOAD: begin
          // A zero denomination gives nothing and keeps the remainder.
          if (rd_denom_q == '0) begin
            j_q     <= j_q + 1'b1;
            state_q <= S_READ;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_CAP;
          end
        end
        S_CAP, S_MUL: begin
          if (state_q == S_CAP && cap) begin
            state_q <= S_MUL;
          end else if (fin_en) begin
            rem_q <= fin_rem;
            if (fin_cnt != '0) begin
              out_valid_q <= 1'b1;
              kind_q      <= KIND_COUNT;
              idx_q       <= IDX_OUT_W'(j_q);
              value_q     <= rd_denom_q;
              count_q     <= COUNT_W'(fin_cnt);
              left_q      <= '0;
              last_q      <= 1'b0;
              state_q     <= S_EMIT;
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= S_READ;
            end
          end
        end
        S_EMIT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (last_q) begin
              state_q <= S_IDLE;
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= S_READ;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign denom_index_o = idx_q;
  assign denom_value_o = value_q;
  assign piece_count_o = count_q;
  assign leftover_o    = left_q;
  assign last_o        = last_q;

  // A change request keeps the block busy in the following cycle.
  `GCD_ASSERT_NEXT(a_req_busy, in_acc && (opcode_i == OP_REQUEST), in_stall_o, "request not held")
  // The final result of a request is a summary, never a count.
  `GCD_ASSERT_SAME(a_last_kind, out_valid_o && last_o, kind_o != KIND_COUNT, "last on count")
  // Results before the final one are counts.
  `GCD_ASSERT_SAME(a_mid_kind, out_valid_o && !last_o, kind_o == KIND_COUNT, "summary not last")
  // A count result always gives at least one piece.
  `GCD_ASSERT_SAME(a_cnt_nz, out_valid_o && (kind_o == KIND_COUNT), piece_count_o != '0, "zero count")
  // The multiplier runs only when counts are capped.
  `GCD_ASSERT_SAME(a_mul_lim, state_q == S_MUL, use_limits_q, "multiply without limits")

endmodule

// ===== rtl/gcd_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module gcd_divider import gcd_pkg::*; #(
  parameter int unsigned RemW = AMOUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [RemW-1:0]    dividend_i,
  input  logic [DENOM_W-1:0] divisor_i,
  output logic               done_o,
  output logic [RemW-1:0]    quotient_o,
  output logic [RemW-1:0]    remainder_o
);

  localparam int unsigned CntW = $clog2(RemW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [RemW-1:0] dvd_q, dvd_d;
  logic [DENOM_W-1:0] part_q, part_d;
  logic [DENOM_W-1:0] dsr_q;
  logic [DENOM_W:0]   trial;
  logic [DENOM_W:0]   diff;

  // One restoring step: bring in the next dividend bit and try a subtract.
  always_comb begin
    trial = {part_q, dvd_q[RemW-1]};
    diff  = trial - {1'b0, dsr_q};
    if (trial >= {1'b0, dsr_q}) begin
      part_d = diff[DENOM_W-1:0];
      dvd_d  = {dvd_q[RemW-2:0], 1'b1};
    end else begin
      part_d = trial[DENOM_W-1:0];
      dvd_d  = {dvd_q[RemW-2:0], 1'b0};
    end
  end

  // Control: step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(RemW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register fills up with quotient bits.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvd_q  <= dividend_i;
      dsr_q  <= divisor_i;
      part_q <= '0;
    end else if (busy_q) begin
      dvd_q  <= dvd_d;
      part_q <= part_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = part_q[RemW-1:0];

endmodule

// ===== rtl/gcd_multiplier.sv =====
// Bit-serial shift-add multiplier of an availability by a denomination.
`timescale 1ns / 1ps

module gcd_multiplier import gcd_pkg::*; #(
  parameter int unsigned RemW = AMOUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [AVAIL_W-1:0] multiplier_i,
  input  logic [RemW-1:0]    multiplicand_i,
  output logic               done_o,
  output logic [RemW-1:0]    product_o
);

  localparam int unsigned CntW = $clog2(AVAIL_W + 1);

  logic               busy_q;
  logic               done_q;
  logic [CntW-1:0]    cnt_q;
  logic [AVAIL_W-1:0] mlr_q;
  logic [RemW-1:0]    mcd_q;
  logic [RemW-1:0]    acc_q, acc_d;

  // MSB-first step: double the sum and add the multiplicand on a one bit.
  always_comb begin
    acc_d = {acc_q[RemW-2:0], 1'b0};
    if (mlr_q[AVAIL_W-1]) begin
      acc_d = acc_d + mcd_q;
    end
  end

  // Control: bit counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(AVAIL_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the multiplier shifts out one bit per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      mlr_q <= multiplier_i;
      mcd_q <= multiplicand_i;
      acc_q <= '0;
    end else if (busy_q) begin
      mlr_q <= {mlr_q[AVAIL_W-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule
